// File: sv/i2cee_pkg.sv
// Package for the serial EEPROM byte master.
// Holds the request codes, register indexes, reset values, phase encoding and
// the types shared by the core, the output buffer and the top level.
package i2cee_pkg;

	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
	localparam logic [1:0] CFG_ACK_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_PHASE_TICKS = 2'd2;

	localparam logic [6:0] DEV_ADDR_RESET    = 7'd80;
	localparam logic [7:0] ACK_LIMIT_RESET   = 8'd200;
	localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
	localparam logic [7:0] NAK_POLL_LIMIT    = 8'd100;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_STA_A    = 5'd1,
		PH_STA_B    = 5'd2,
		PH_STA_C    = 5'd3,
		PH_WB_PREP  = 5'd4,
		PH_WB_HIGH  = 5'd5,
		PH_WB_LOW   = 5'd6,
		PH_WB_REL   = 5'd7,
		PH_ACK_HIGH = 5'd8,
		PH_ACK_POLL = 5'd9,
		PH_ACK_LOW  = 5'd10,
		PH_RB_PREP  = 5'd11,
		PH_RB_REL   = 5'd12,
		PH_RB_HIGH  = 5'd13,
		PH_RB_LOW   = 5'd14,
		PH_NAK_HIGH = 5'd15,
		PH_NAK_POLL = 5'd16,
		PH_NAK_LOW  = 5'd17,
		PH_STO_A    = 5'd18,
		PH_STO_B    = 5'd19,
		PH_STO_C    = 5'd20
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] bit_count;
		logic [7:0] shift_reg;
		logic [7:0] delay_count;
		logic [7:0] wait_count;
		logic [1:0] latched_op;
		logic [7:0] latched_addr;
		logic [7:0] latched_data;
		logic       ack_flag;
		logic [7:0] read_reg;
		logic [1:0] ack_count;
		logic       scl;
		logic       sda;
	} state_t;

	typedef struct packed {
		logic       ack_missing;
		logic [7:0] read_data;
		logic       done;
		logic       busy;
		logic       sda_out;
		logic       scl;
	} result_t;

endpackage

// File: sv/i2cee_core.sv
// Bus sequencer of the serial EEPROM byte master: configuration registers,
// transaction state and the one-tick next-state logic. Uses i2cee_pkg.
module i2cee_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           op,
	input  logic [7:0]           word_addr,
	input  logic [7:0]           write_data,
	input  logic                 sda_in,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_wdata,
	output i2cee_pkg::result_t   res
);

	localparam i2cee_pkg::state_t StReset = '{
		phase:        i2cee_pkg::PH_IDLE,
		bit_count:    3'd0,
		shift_reg:    8'd0,
		delay_count:  8'd0,
		wait_count:   8'd0,
		latched_op:   2'd0,
		latched_addr: 8'd0,
		latched_data: 8'd0,
		ack_flag:     1'b0,
		read_reg:     8'd0,
		ack_count:    2'd0,
		scl:          1'b1,
		sda:          1'b1
	};

	logic [6:0]          dev_addr_q;
	logic [7:0]          ack_limit_q;
	logic [7:0]          phase_ticks_q;
	i2cee_pkg::state_t   st_q;
	i2cee_pkg::state_t   st_d;
	logic                done;

	function automatic i2cee_pkg::state_t enter_phase(input i2cee_pkg::state_t s,
			input i2cee_pkg::phase_t p);
		i2cee_pkg::state_t r;
		r = s;
		r.phase = p;
		r.delay_count = 8'd0;
		case (p)
			i2cee_pkg::PH_STA_A, i2cee_pkg::PH_STO_B, i2cee_pkg::PH_ACK_HIGH,
			i2cee_pkg::PH_RB_HIGH, i2cee_pkg::PH_NAK_HIGH: begin
				r.scl = 1'b1;
			end
			i2cee_pkg::PH_STA_B, i2cee_pkg::PH_WB_REL, i2cee_pkg::PH_RB_REL,
			i2cee_pkg::PH_STO_C: begin
				r.sda = 1'b1;
			end
			i2cee_pkg::PH_STA_C, i2cee_pkg::PH_STO_A: begin
				r.sda = 1'b0;
			end
			i2cee_pkg::PH_WB_PREP, i2cee_pkg::PH_WB_LOW, i2cee_pkg::PH_ACK_LOW,
			i2cee_pkg::PH_RB_PREP, i2cee_pkg::PH_RB_LOW, i2cee_pkg::PH_NAK_LOW: begin
				r.scl = 1'b0;
			end
			i2cee_pkg::PH_WB_HIGH: begin
				r.sda = s.shift_reg[7];
				r.scl = 1'b1;
			end
			i2cee_pkg::PH_ACK_POLL, i2cee_pkg::PH_NAK_POLL: begin
				r.wait_count = 8'd0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= i2cee_pkg::DEV_ADDR_RESET;
			ack_limit_q   <= i2cee_pkg::ACK_LIMIT_RESET;
			phase_ticks_q <= i2cee_pkg::PHASE_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cee_pkg::CFG_DEV_ADDR:    dev_addr_q    <= cfg_wdata[6:0];
				i2cee_pkg::CFG_ACK_LIMIT:   ack_limit_q   <= cfg_wdata;
				i2cee_pkg::CFG_PHASE_TICKS: phase_ticks_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		i2cee_pkg::state_t s;
		i2cee_pkg::phase_t nxt;
		logic              go;
		logic [7:0]        pt;
		logic [1:0]        acks;
		s    = st_q;
		nxt  = st_q.phase;
		go   = 1'b0;
		done = 1'b0;
		acks = st_q.ack_count + 2'd1;
		pt   = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;

		if (s.phase == i2cee_pkg::PH_IDLE &&
				(op == i2cee_pkg::OP_WRITE || op == i2cee_pkg::OP_READ)) begin
			s.latched_op   = op;
			s.latched_addr = word_addr;
			s.latched_data = write_data;
			s.ack_flag     = 1'b0;
			s.ack_count    = 2'd0;
			s = enter_phase(s, i2cee_pkg::PH_STA_A);
		end

		if (s.phase == i2cee_pkg::PH_ACK_POLL) begin
			if (!sda_in) begin
				s = enter_phase(s, i2cee_pkg::PH_ACK_LOW);
			end else if (s.wait_count >= ack_limit_q) begin
				s.ack_flag = 1'b1;
				s = enter_phase(s, i2cee_pkg::PH_ACK_LOW);
			end else begin
				s.wait_count = s.wait_count + 8'd1;
			end
		end else if (s.phase == i2cee_pkg::PH_NAK_POLL) begin
			if (sda_in || s.wait_count >= i2cee_pkg::NAK_POLL_LIMIT) begin
				s = enter_phase(s, i2cee_pkg::PH_NAK_LOW);
			end else begin
				s.wait_count = s.wait_count + 8'd1;
			end
		end else if (s.phase != i2cee_pkg::PH_IDLE) begin
			s.delay_count = s.delay_count + 8'd1;
			if (s.delay_count >= pt) begin
				go = 1'b1;
				case (s.phase)
					i2cee_pkg::PH_STA_A: nxt = i2cee_pkg::PH_STA_B;
					i2cee_pkg::PH_STA_B: nxt = i2cee_pkg::PH_STA_C;
					i2cee_pkg::PH_STA_C: begin
						s.shift_reg = {dev_addr_q, (s.ack_count != 2'd0)};
						nxt = i2cee_pkg::PH_WB_PREP;
					end
					i2cee_pkg::PH_WB_PREP: begin
						s.bit_count = 3'd0;
						nxt = i2cee_pkg::PH_WB_HIGH;
					end
					i2cee_pkg::PH_WB_HIGH: begin
						s.shift_reg = {s.shift_reg[6:0], 1'b0};
						nxt = i2cee_pkg::PH_WB_LOW;
					end
					i2cee_pkg::PH_WB_LOW: begin
						if (s.bit_count == 3'd7) begin
							nxt = i2cee_pkg::PH_WB_REL;
						end else begin
							s.bit_count = s.bit_count + 3'd1;
							nxt = i2cee_pkg::PH_WB_HIGH;
						end
					end
					i2cee_pkg::PH_WB_REL:   nxt = i2cee_pkg::PH_ACK_HIGH;
					i2cee_pkg::PH_ACK_HIGH: nxt = i2cee_pkg::PH_ACK_POLL;
					i2cee_pkg::PH_ACK_LOW: begin
						s.ack_count = acks;
						if (acks == 2'd1) begin
							s.shift_reg = s.latched_addr;
							nxt = i2cee_pkg::PH_WB_PREP;
						end else if (s.latched_op == i2cee_pkg::OP_WRITE) begin
							if (acks == 2'd2) begin
								s.shift_reg = s.latched_data;
								nxt = i2cee_pkg::PH_WB_PREP;
							end else begin
								nxt = i2cee_pkg::PH_STO_A;
							end
						end else if (acks == 2'd2) begin
							nxt = i2cee_pkg::PH_STA_A;
						end else begin
							s.shift_reg = 8'd0;
							nxt = i2cee_pkg::PH_RB_PREP;
						end
					end
					i2cee_pkg::PH_RB_PREP: begin
						s.bit_count = 3'd0;
						nxt = i2cee_pkg::PH_RB_REL;
					end
					i2cee_pkg::PH_RB_REL: nxt = i2cee_pkg::PH_RB_HIGH;
					i2cee_pkg::PH_RB_HIGH: begin
						s.shift_reg = {s.shift_reg[6:0], sda_in};
						nxt = i2cee_pkg::PH_RB_LOW;
					end
					i2cee_pkg::PH_RB_LOW: begin
						if (s.bit_count == 3'd7) begin
							s.read_reg = s.shift_reg;
							nxt = i2cee_pkg::PH_NAK_HIGH;
						end else begin
							s.bit_count = s.bit_count + 3'd1;
							nxt = i2cee_pkg::PH_RB_HIGH;
						end
					end
					i2cee_pkg::PH_NAK_HIGH: nxt = i2cee_pkg::PH_NAK_POLL;
					i2cee_pkg::PH_NAK_LOW:  nxt = i2cee_pkg::PH_STO_A;
					i2cee_pkg::PH_STO_A:    nxt = i2cee_pkg::PH_STO_B;
					i2cee_pkg::PH_STO_B:    nxt = i2cee_pkg::PH_STO_C;
					i2cee_pkg::PH_STO_C: begin
						done = 1'b1;
						nxt = i2cee_pkg::PH_IDLE;
					end
					default: nxt = i2cee_pkg::PH_IDLE;
				endcase
			end
		end

		if (go) begin
			s = enter_phase(s, nxt);
		end
		st_d = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StReset;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	assign res.scl         = st_d.scl;
	assign res.sda_out     = st_d.sda;
	assign res.busy        = (st_d.phase != i2cee_pkg::PH_IDLE);
	assign res.done        = done;
	assign res.read_data   = st_d.read_reg;
	assign res.ack_missing = st_d.ack_flag;

endmodule

// File: sv/i2cee_outbuf.sv
// Result register with a skid stage for the serial EEPROM byte master.
// Takes one result_t per accepted beat; depends on i2cee_pkg.
module i2cee_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i2cee_pkg::result_t   push_data,
	output logic                 push_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output i2cee_pkg::result_t   out_data
);

	logic                 main_valid_q;
	logic                 skid_valid_q;
	i2cee_pkg::result_t   main_q;
	i2cee_pkg::result_t   skid_q;
	logic                 pop;

	assign pop        = main_valid_q & out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// File: sv/i2c_eeprom_byte_master.sv
// Top level of the serial EEPROM byte master (byte write and random read).
// Instantiates i2cee_core and i2cee_outbuf; uses i2cee_pkg.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one bus tick: request code, word address, data, SDA level
//   m_axis    out        one result per tick: line levels, status, read byte
//   cfg       in         register write: index 0 address, 1 ack limit, 2 ticks
//
// One input beat can be taken every cycle while s_axis_tready is high and gives
// exactly one result beat; the result leaves through the output register.
// A two-entry output buffer (register plus skid) keeps s_axis_tready high while
// one result waits, so the rate drops only when both entries are held.
// Reset loads the register defaults and returns the sequencer to idle.
module i2c_eeprom_byte_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // word_addr[7:0], write_data[15:8], sda_in[16], zero
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // scl, sda_out, busy_res, done_res,
	                                   // read_data[11:4], ack_missing[12], zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic                 accept;
	i2cee_pkg::result_t   core_res;
	i2cee_pkg::result_t   out_res;

	assign accept = s_axis_tvalid & s_axis_tready;

	i2cee_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (s_axis_tuser),
		.word_addr  (s_axis_tdata[7:0]),
		.write_data (s_axis_tdata[15:8]),
		.sda_in     (s_axis_tdata[16]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.res        (core_res)
	);

	i2cee_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (core_res),
		.push_ready (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (out_res)
	);

	assign m_axis_tdata = {3'b000, out_res.ack_missing, out_res.read_data, out_res.done,
		out_res.busy, out_res.sda_out, out_res.scl};

endmodule

// File: sv/i2cee_checker.sv
// Port-level checks for the serial EEPROM byte master, bound to the top level.
// Sees only the top-level ports; no package dependency.
module i2cee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// Input stalls only while results are backed up at the output.
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// A beat taken into an empty output shows up on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
		else $error("accepted beat produced no result");

	// The stop-complete beat always reports the bus as free.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
		else $error("done beat still marked busy");

	// A stalled result beat holds its payload.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

bind i2c_eeprom_byte_master i2cee_checker u_i2cee_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/i2c_eeprom_byte_master_tb.sv
// Testbench for the serial EEPROM byte master: byte writes and random reads
// driven tick by tick, every result beat checked against a local bus predictor.
// Depends on i2cee_pkg and the i2c_eeprom_byte_master top level.
module i2c_eeprom_byte_master_tb;
	import i2cee_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TOTAL_BEATS = 1400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = OP_NONE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_DEV_ADDR;
	logic [7:0]  cfg_wdata = '0;

	i2c_eeprom_byte_master DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	state_t     bus_state;
	logic [6:0] dev_addr;
	logic [7:0] ack_limit;
	logic [7:0] tick_len;
	result_t    pending_ticks[$];
	result_t    want;
	int         mismatches = 0;
	int         beats_sent = 0;
	int         cycle_count = 0;
	int         burst_left = 0;
	bit         gaps_on = 1'b1;
	bit         pressure_on = 1'b0;
	bit         ack_refuse = 1'b0;
	bit         nak_hold = 1'b0;
	int         rx_mode = 0;
	int         rx_cycle = 0;

	function automatic void move_to(phase_t p);
		bus_state.phase = p;
		bus_state.delay_count = '0;
		case (p)
			PH_STA_A, PH_STO_B, PH_ACK_HIGH, PH_RB_HIGH, PH_NAK_HIGH: bus_state.scl = 1'b1;
			PH_STA_B, PH_WB_REL, PH_RB_REL, PH_STO_C: bus_state.sda = 1'b1;
			PH_STA_C, PH_STO_A: bus_state.sda = 1'b0;
			PH_WB_PREP, PH_WB_LOW, PH_ACK_LOW, PH_RB_PREP, PH_RB_LOW, PH_NAK_LOW:
				bus_state.scl = 1'b0;
			PH_WB_HIGH: begin
				bus_state.sda = bus_state.shift_reg[7];
				bus_state.scl = 1'b1;
			end
			PH_ACK_POLL, PH_NAK_POLL: bus_state.wait_count = '0;
			default: ;
		endcase
	endfunction

	function automatic void load_byte(logic [7:0] b);
		bus_state.shift_reg = b;
		move_to(PH_WB_PREP);
	endfunction

	function automatic logic end_of_phase(logic sda);
		case (bus_state.phase)
			PH_STA_A: move_to(PH_STA_B);
			PH_STA_B: move_to(PH_STA_C);
			PH_STA_C: load_byte({dev_addr, bus_state.ack_count != 2'd0});
			PH_WB_PREP: begin
				bus_state.bit_count = '0;
				move_to(PH_WB_HIGH);
			end
			PH_WB_HIGH: begin
				bus_state.shift_reg = {bus_state.shift_reg[6:0], 1'b0};
				move_to(PH_WB_LOW);
			end
			PH_WB_LOW: begin
				if (bus_state.bit_count >= 3'd7) begin
					move_to(PH_WB_REL);
				end else begin
					bus_state.bit_count = bus_state.bit_count + 3'd1;
					move_to(PH_WB_HIGH);
				end
			end
			PH_WB_REL: move_to(PH_ACK_HIGH);
			PH_ACK_HIGH: move_to(PH_ACK_POLL);
			PH_ACK_LOW: begin
				bus_state.ack_count = bus_state.ack_count + 2'd1;
				if (bus_state.ack_count == 2'd1) begin
					load_byte(bus_state.latched_addr);
				end else if (bus_state.latched_op == OP_WRITE) begin
					if (bus_state.ack_count == 2'd2) load_byte(bus_state.latched_data);
					else move_to(PH_STO_A);
				end else begin
					if (bus_state.ack_count == 2'd2) begin
						move_to(PH_STA_A);
					end else begin
						bus_state.shift_reg = '0;
						move_to(PH_RB_PREP);
					end
				end
			end
			PH_RB_PREP: begin
				bus_state.bit_count = '0;
				move_to(PH_RB_REL);
			end
			PH_RB_REL: move_to(PH_RB_HIGH);
			PH_RB_HIGH: begin
				bus_state.shift_reg = {bus_state.shift_reg[6:0], sda};
				move_to(PH_RB_LOW);
			end
			PH_RB_LOW: begin
				if (bus_state.bit_count >= 3'd7) begin
					bus_state.read_reg = bus_state.shift_reg;
					move_to(PH_NAK_HIGH);
				end else begin
					bus_state.bit_count = bus_state.bit_count + 3'd1;
					move_to(PH_RB_HIGH);
				end
			end
			PH_NAK_HIGH: move_to(PH_NAK_POLL);
			PH_NAK_LOW: move_to(PH_STO_A);
			PH_STO_A: move_to(PH_STO_B);
			PH_STO_B: move_to(PH_STO_C);
			PH_STO_C: begin
				move_to(PH_IDLE);
				return 1'b1;
			end
			default: move_to(PH_IDLE);
		endcase
		return 1'b0;
	endfunction

	function automatic result_t predict_tick(logic [1:0] op, logic [7:0] addr,
			logic [7:0] data, logic sda);
		logic [7:0] ticks;
		logic       stop_done;
		result_t    r;
		ticks = (tick_len == 8'd0) ? 8'd1 : tick_len;
		stop_done = 1'b0;
		if (bus_state.phase == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
			bus_state.latched_op = op;
			bus_state.latched_addr = addr;
			bus_state.latched_data = data;
			bus_state.ack_flag = 1'b0;
			bus_state.ack_count = '0;
			move_to(PH_STA_A);
		end
		if (bus_state.phase == PH_ACK_POLL) begin
			if (sda == 1'b0) begin
				move_to(PH_ACK_LOW);
			end else if (bus_state.wait_count >= ack_limit) begin
				bus_state.ack_flag = 1'b1;
				move_to(PH_ACK_LOW);
			end else begin
				bus_state.wait_count = bus_state.wait_count + 8'd1;
			end
		end else if (bus_state.phase == PH_NAK_POLL) begin
			if (sda == 1'b1 || bus_state.wait_count >= NAK_POLL_LIMIT) move_to(PH_NAK_LOW);
			else bus_state.wait_count = bus_state.wait_count + 8'd1;
		end else if (bus_state.phase != PH_IDLE) begin
			bus_state.delay_count = bus_state.delay_count + 8'd1;
			if (bus_state.delay_count >= ticks) stop_done = end_of_phase(sda);
		end
		r.scl = bus_state.scl;
		r.sda_out = bus_state.sda;
		r.busy = (bus_state.phase != PH_IDLE);
		r.done = stop_done;
		r.read_data = bus_state.read_reg;
		r.ack_missing = bus_state.ack_flag;
		return r;
	endfunction

	function automatic logic pick_sda();
		case (bus_state.phase)
			PH_ACK_POLL: return (ack_refuse && bus_state.ack_count == 2'd0) ? 1'b1 :
				($urandom_range(0, 3) == 0);
			PH_NAK_POLL: return nak_hold ? 1'b0 : ($urandom_range(0, 3) != 0);
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [7:0] addr,
			input logic [7:0] data, input logic sda);
		if (gaps_on && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0) burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {7'd0, sda, data, addr};
		do @(posedge clk); while (!s_axis_tready);
		pending_ticks.push_back(predict_tick(op, addr, data, sda));
		beats_sent++;
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_ticks.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		case (index)
			CFG_DEV_ADDR: dev_addr = value[6:0];
			CFG_ACK_LIMIT: ack_limit = value;
			CFG_PHASE_TICKS: tick_len = value;
			default: ;
		endcase
	endtask

	task automatic reconfigure(input logic [7:0] dev, input logic [7:0] limit,
			input logic [7:0] ticks);
		while (bus_state.phase != PH_IDLE) send_beat(OP_NONE, '0, '0, pick_sda());
		hold_until_drained();
		repeat (4) @(posedge clk);
		write_reg(CFG_DEV_ADDR, dev);
		write_reg(CFG_ACK_LIMIT, limit);
		write_reg(CFG_PHASE_TICKS, ticks);
		cfg_we <= 1'b0;
	endtask

	task automatic run_transfer(input logic [1:0] op, input logic [7:0] addr,
			input logic [7:0] data, input bit refuse, input bit hold_low);
		logic [1:0] busy_op;
		ack_refuse = refuse;
		nak_hold = hold_low;
		send_beat(op, addr, data, pick_sda());
		while (bus_state.phase != PH_IDLE) begin
			busy_op = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : OP_NONE;
			if (pressure_on && $urandom_range(0, 299) == 0) hold_until_drained();
			send_beat(busy_op, 8'($urandom), 8'($urandom), pick_sda());
		end
	endtask

	task automatic send_idle_noise(input int n);
		logic [1:0] idle_op;
		repeat (n) begin
			idle_op = $urandom_range(0, 1) ? OP_UNUSED : OP_NONE;
			send_beat(idle_op, 8'($urandom), 8'($urandom), pick_sda());
		end
	endtask

	task automatic test_default_settings();
		run_transfer(OP_WRITE, 8'h00, 8'hFF, 1'b0, 1'b0);
		run_transfer(OP_READ, 8'hFF, 8'h00, 1'b0, 1'b0);
	endtask

	task automatic test_device_address();
		gaps_on = 1'b0;
		reconfigure(8'h00, 8'd200, 8'd1);
		run_transfer(OP_WRITE, 8'hA5, 8'h5A, 1'b0, 1'b0);
		run_transfer(OP_READ, 8'h5A, 8'hA5, 1'b0, 1'b0);
		reconfigure(8'hFF, 8'd200, 8'd1);
		run_transfer(OP_READ, 8'h80, 8'h01, 1'b0, 1'b0);
		run_transfer(OP_WRITE, 8'h7F, 8'h80, 1'b0, 1'b0);
		gaps_on = 1'b1;
	endtask

	task automatic test_ignored_requests();
		send_idle_noise(8);
		run_transfer(OP_WRITE, 8'h3C, 8'hC3, 1'b0, 1'b0);
		send_idle_noise(4);
	endtask

	task automatic test_ack_timeouts();
		reconfigure(8'h50, 8'd0, 8'd1);
		run_transfer(OP_WRITE, 8'h11, 8'h22, 1'b1, 1'b0);
		run_transfer(OP_READ, 8'h33, 8'h44, 1'b1, 1'b1);
		run_transfer(OP_WRITE, 8'h55, 8'h66, 1'b0, 1'b0);
		reconfigure(8'h50, 8'd255, 8'd1);
		run_transfer(OP_WRITE, 8'h77, 8'h88, 1'b1, 1'b0);
		run_transfer(OP_READ, 8'h99, 8'hAA, 1'b0, 1'b1);
	endtask

	task automatic test_phase_ticks();
		reconfigure(8'h2A, 8'd10, 8'd0);
		run_transfer(OP_WRITE, 8'h01, 8'hFE, 1'b0, 1'b0);
		run_transfer(OP_READ, 8'hFE, 8'h01, 1'b0, 1'b0);
		reconfigure(8'h55, 8'd10, 8'd2);
		run_transfer(OP_READ, 8'h10, 8'h20, 1'b0, 1'b0);
		reconfigure(8'h15, 8'd5, 8'd3);
		run_transfer(OP_WRITE, 8'hC0, 8'h0C, 1'b0, 1'b0);
		run_transfer(OP_READ, 8'h0C, 8'hC0, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [7:0] limit;
		logic [7:0] ticks;
		logic [1:0] op;
		pressure_on = 1'b1;
		do begin
			limit = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
			ticks = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
			reconfigure(8'($urandom), limit, ticks);
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3)) begin
				op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
				run_transfer(op, 8'($urandom), 8'($urandom),
					$urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
				if ($urandom_range(0, 4) == 0) send_idle_noise($urandom_range(1, 3));
			end
		end while (beats_sent < TOTAL_BEATS);
		gaps_on = 1'b1;
		pressure_on = 1'b0;
	endtask

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_ticks.size() == 0) begin
				$error("result beat arrived with no expected result");
				mismatches++;
			end else begin
				want = pending_ticks.pop_front();
				check_field("scl", want.scl, m_axis_tdata[0]);
				check_field("sda_out", want.sda_out, m_axis_tdata[1]);
				check_field("busy_res", want.busy, m_axis_tdata[2]);
				check_field("done_res", want.done, m_axis_tdata[3]);
				check_field("read_data", want.read_data, m_axis_tdata[11:4]);
				check_field("ack_missing", want.ack_missing, m_axis_tdata[12]);
			end
		end
		rx_cycle++;
		if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= (rx_cycle % 7 >= 3);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		bus_state = '0;
		bus_state.phase = PH_IDLE;
		bus_state.scl = 1'b1;
		bus_state.sda = 1'b1;
		dev_addr = DEV_ADDR_RESET;
		ack_limit = ACK_LIMIT_RESET;
		tick_len = PHASE_TICKS_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_settings();
		test_device_address();
		test_ignored_requests();
		test_ack_timeouts();
		test_phase_ticks();
		test_random_traffic();
		hold_until_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_ticks.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
